@@ design/nscd_pkg.sv @@
// Shared types and constants for the NMEA sentence checksum deframer.
// Holds the character codes, the result codes, the result record and the hex decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nscd_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [23:0] TAIL_GGA = 24'h474741;
    localparam logic [23:0] TAIL_RMC = 24'h524D43;

    localparam logic [1:0] STATUS_VALID    = 2'd0;
    localparam logic [1:0] STATUS_ERROR    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_GGA   = 2'd1;
    localparam logic [1:0] KIND_RMC   = 2'd2;

    localparam int RESULT_BITS = 115;
    localparam int TDATA_BITS  = 120;

    typedef struct packed {
        logic [31:0] overflow_total;
        logic [31:0] error_total;
        logic [31:0] valid_total;
        logic [7:0]  computed_checksum;
        logic [6:0]  stored_length;
        logic [1:0]  sentence_kind;
        logic [1:0]  status;
    } nscd_result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } nscd_nibble_t;

    function automatic nscd_nibble_t hex_nibble(input logic [7:0] c);
        nscd_nibble_t r;
        r.ok    = 1'b1;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.value = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.value = 4'(c - 8'h57);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/nscd_frame.sv @@
// Per-byte sentence tracker: framing, checksum, hex digits, type tail and totals.
// Produces at most one result record in the cycle a byte is taken.
// Depends on nscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nscd_frame
    import nscd_pkg::*;
#(
    parameter int BUFFER_BYTES = 128
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         byte_en,
    input  wire logic [7:0]   rx_byte,
    output logic              res_valid,
    output nscd_result_t      res
);

    localparam int LEN_W = $clog2(BUFFER_BYTES);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(BUFFER_BYTES - 1);

    logic             collecting_reg, collecting_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [7:0]       sum_reg, sum_next;
    logic             star_reg, star_next;
    logic             zero_reg, zero_next;
    logic [1:0]       hex_cnt_reg, hex_cnt_next;
    logic [7:0]       hex_val_reg, hex_val_next;
    logic             hex_bad_reg, hex_bad_next;
    logic             in_type_reg, in_type_next;
    logic [23:0]      tail_reg, tail_next;
    logic [1:0]       type_len_reg, type_len_next;
    logic [31:0]      valid_cnt_reg, valid_cnt_next;
    logic [31:0]      error_cnt_reg, error_cnt_next;
    logic [31:0]      ovf_cnt_reg, ovf_cnt_next;

    nscd_nibble_t     nib;
    logic             sum_ok;
    logic [LEN_W+6:0] length_ext;

    assign nib        = hex_nibble(rx_byte);
    assign sum_ok     = star_reg && (hex_cnt_reg == 2'd2) && !hex_bad_reg
                        && (hex_val_reg == sum_reg);
    assign length_ext = {7'd0, length_reg};

    always_comb begin
        collecting_next = collecting_reg;
        length_next     = length_reg;
        sum_next        = sum_reg;
        star_next       = star_reg;
        zero_next       = zero_reg;
        hex_cnt_next    = hex_cnt_reg;
        hex_val_next    = hex_val_reg;
        hex_bad_next    = hex_bad_reg;
        in_type_next    = in_type_reg;
        tail_next       = tail_reg;
        type_len_next   = type_len_reg;
        valid_cnt_next  = valid_cnt_reg;
        error_cnt_next  = error_cnt_reg;
        ovf_cnt_next    = ovf_cnt_reg;
        res_valid       = 1'b0;
        res.status            = STATUS_VALID;
        res.sentence_kind     = KIND_OTHER;
        res.stored_length     = length_ext[6:0];
        res.computed_checksum = sum_reg;

        if (byte_en) begin
            if (rx_byte == CH_DOLLAR) begin
                collecting_next = 1'b1;
                length_next     = LEN_W'(1);
                sum_next        = 8'd0;
                star_next       = 1'b0;
                zero_next       = 1'b0;
                hex_cnt_next    = 2'd0;
                hex_val_next    = 8'd0;
                hex_bad_next    = 1'b0;
                in_type_next    = 1'b1;
                tail_next       = 24'd0;
                type_len_next   = 2'd0;
            end else if (collecting_reg && rx_byte != CH_CR) begin
                if (rx_byte == CH_LF) begin
                    collecting_next = 1'b0;
                    res_valid       = 1'b1;
                    if (sum_ok) begin
                        valid_cnt_next = valid_cnt_reg + 32'd1;
                        if (type_len_reg == 2'd3 && tail_reg == TAIL_GGA) begin
                            res.sentence_kind = KIND_GGA;
                        end else if (type_len_reg == 2'd3 && tail_reg == TAIL_RMC) begin
                            res.sentence_kind = KIND_RMC;
                        end
                    end else begin
                        error_cnt_next = error_cnt_reg + 32'd1;
                        res.status     = STATUS_ERROR;
                    end
                end else if (length_reg >= LEN_LIMIT) begin
                    // storing this byte would fill the buffer
                    collecting_next       = 1'b0;
                    length_next           = '0;
                    ovf_cnt_next          = ovf_cnt_reg + 32'd1;
                    res_valid             = 1'b1;
                    res.status            = STATUS_OVERFLOW;
                    res.stored_length     = 7'd0;
                    res.computed_checksum = 8'd0;
                end else begin
                    length_next = length_reg + LEN_W'(1);
                    if (!zero_reg) begin
                        if (rx_byte == CH_NUL) begin
                            zero_next    = 1'b1;
                            in_type_next = 1'b0;
                        end else begin
                            if (!star_reg) begin
                                if (rx_byte == CH_STAR) begin
                                    star_next = 1'b1;
                                end else begin
                                    sum_next = sum_reg ^ rx_byte;
                                end
                            end else if (hex_cnt_reg != 2'd2) begin
                                if (nib.ok) begin
                                    hex_val_next = {hex_val_reg[3:0], nib.value};
                                end else begin
                                    hex_bad_next = 1'b1;
                                end
                                hex_cnt_next = hex_cnt_reg + 2'd1;
                            end
                            if (in_type_reg) begin
                                if (rx_byte == CH_COMMA || rx_byte == CH_STAR) begin
                                    in_type_next = 1'b0;
                                end else begin
                                    tail_next = {tail_reg[15:0], rx_byte};
                                    if (type_len_reg != 2'd3) begin
                                        type_len_next = type_len_reg + 2'd1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
        end

        res.valid_total    = valid_cnt_next;
        res.error_total    = error_cnt_next;
        res.overflow_total = ovf_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            length_reg     <= '0;
            sum_reg        <= 8'd0;
            star_reg       <= 1'b0;
            zero_reg       <= 1'b0;
            hex_cnt_reg    <= 2'd0;
            hex_val_reg    <= 8'd0;
            hex_bad_reg    <= 1'b0;
            in_type_reg    <= 1'b0;
            tail_reg       <= 24'd0;
            type_len_reg   <= 2'd0;
            valid_cnt_reg  <= 32'd0;
            error_cnt_reg  <= 32'd0;
            ovf_cnt_reg    <= 32'd0;
        end else begin
            collecting_reg <= collecting_next;
            length_reg     <= length_next;
            sum_reg        <= sum_next;
            star_reg       <= star_next;
            zero_reg       <= zero_next;
            hex_cnt_reg    <= hex_cnt_next;
            hex_val_reg    <= hex_val_next;
            hex_bad_reg    <= hex_bad_next;
            in_type_reg    <= in_type_next;
            tail_reg       <= tail_next;
            type_len_reg   <= type_len_next;
            valid_cnt_reg  <= valid_cnt_next;
            error_cnt_reg  <= error_cnt_next;
            ovf_cnt_reg    <= ovf_cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ design/nscd_out_reg.sv @@
// Result output register with one skid entry, so input stays open while a result waits.
// Depends on nscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nscd_out_reg
    import nscd_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  nscd_result_t       push_data,
    output logic               can_accept,
    output logic               out_valid,
    input  wire logic          out_ready,
    output nscd_result_t       out_data
);

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    nscd_result_t main_reg, main_next;
    nscd_result_t skid_reg, skid_next;
    logic         pop;

    assign pop        = main_valid_reg && out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

@@ design/nmea_sentence_checksum_deframer_unit.sv @@
// Top level of the NMEA sentence checksum deframer.
// Instantiates nscd_frame and nscd_out_reg; depends on nscd_pkg.
//
//  channel | dir | tdata fields (low bit first)                    | tuser
//  s_      | in  | rx_byte[7:0]                                    | -
//  m_      | out | status, sentence_kind, stored_length,           | -
//          |     | computed_checksum, valid/error/overflow totals  |
//
// One byte per cycle while s_tready is high; each result is registered in nscd_out_reg
// before it appears on m_; all per-byte work is a single pass through nscd_frame.
// Reset (aresetn low, synchronous) clears sentence state and all totals.
// A stalled result sits in the output register; a second one goes to the skid
// entry, and s_tready drops only while that entry is occupied.
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_checksum_deframer_unit
    import nscd_pkg::*;
#(
    parameter int BUFFER_BYTES = 128
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [1:0] status, [3:2] sentence_kind, [10:4] stored_length,
    // [18:11] computed_checksum, [50:19] valid_total, [82:51] error_total,
    // [114:83] overflow_total, [119:115] zero
    output logic [TDATA_BITS-1:0]      m_tdata
);

    logic         s_xfer;
    logic         res_valid;
    nscd_result_t res;
    nscd_result_t out_res;

    assign s_xfer = s_tvalid && s_tready;

    nscd_frame #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (s_xfer),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    nscd_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_valid),
        .push_data  (res),
        .can_accept (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    assign m_tdata = {{(TDATA_BITS - RESULT_BITS){1'b0}}, out_res};

endmodule

`default_nettype wire
